// ===== hw/rtl/ec2d_pkg.sv =====
// ec2d_pkg: shared constants for the 2D elastic collision pipeline.
// No dependencies; used by ec2d_in_if, the multiplier, the divider and the top level.
`default_nettype none

package ec2d_pkg;

    localparam int MASS_W  = 16;          // Q8.8 mass
    localparam int MSUM_W  = MASS_W + 1;  // mass sum, doubled mass
    localparam int Q_W     = 41;          // quotient bits kept by the divider
    localparam int CHUNK_W = 32;          // slice width of the wide multiplier

    // velocity change magnitude is clamped to this value
    localparam logic [Q_W-1:0] SHARE_CAP = {1'b1, {(Q_W-1){1'b0}}};

endpackage

`default_nettype wire

// ===== hw/rtl/ec2d_in_if.sv =====
// ec2d_in_if / ec2d_out_if: valid-ready channels carrying one collision request
// and one collision result. ec2d_in_if depends on ec2d_pkg.
`default_nettype none

interface ec2d_in_if import ec2d_pkg::*; #(
    parameter int COORD_WIDTH = 24
) ();
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] first_pos_x;
    logic signed [COORD_WIDTH-1:0] first_pos_y;
    logic signed [COORD_WIDTH-1:0] first_vel_x;
    logic signed [COORD_WIDTH-1:0] first_vel_y;
    logic        [MASS_W-1:0]      first_mass;
    logic signed [COORD_WIDTH-1:0] second_pos_x;
    logic signed [COORD_WIDTH-1:0] second_pos_y;
    logic signed [COORD_WIDTH-1:0] second_vel_x;
    logic signed [COORD_WIDTH-1:0] second_vel_y;
    logic        [MASS_W-1:0]      second_mass;

    modport source (
        output valid, first_pos_x, first_pos_y, first_vel_x, first_vel_y, first_mass,
               second_pos_x, second_pos_y, second_vel_x, second_vel_y, second_mass,
        input  ready
    );
    modport sink (
        input  valid, first_pos_x, first_pos_y, first_vel_x, first_vel_y, first_mass,
               second_pos_x, second_pos_y, second_vel_x, second_vel_y, second_mass,
        output ready
    );
endinterface

interface ec2d_out_if #(
    parameter int COORD_WIDTH = 24
) ();
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] first_new_vel_x;
    logic signed [COORD_WIDTH-1:0] first_new_vel_y;
    logic signed [COORD_WIDTH-1:0] second_new_vel_x;
    logic signed [COORD_WIDTH-1:0] second_new_vel_y;
    logic                          approaching;
    logic                          degenerate;

    modport source (
        output valid, first_new_vel_x, first_new_vel_y, second_new_vel_x,
               second_new_vel_y, approaching, degenerate,
        input  ready
    );
    modport sink (
        input  valid, first_new_vel_x, first_new_vel_y, second_new_vel_x,
               second_new_vel_y, approaching, degenerate,
        output ready
    );
endinterface

`default_nettype wire

// ===== hw/rtl/ec2d_wmul.sv =====
// ec2d_wmul: two-stage unsigned wide multiplier, A cut into CHUNK_W slices.
// Depends on ec2d_pkg.
`default_nettype none

module ec2d_wmul import ec2d_pkg::*; #(
    parameter int AW = 50,
    parameter int BW = 17
) (
    input  wire logic             i_clk,
    input  wire logic             i_en,
    input  wire logic [AW-1:0]    i_a,
    input  wire logic [BW-1:0]    i_b,
    output logic      [AW+BW-1:0] o_p
);
    localparam int NC    = (AW + CHUNK_W - 1) / CHUNK_W;
    localparam int PADW  = NC * CHUNK_W;
    localparam int PPW   = CHUNK_W + BW;

    logic [PADW-1:0]    a_pad;
    logic [PPW-1:0]     r_pp [NC];
    logic [PADW+BW-1:0] n_acc;
    logic [AW+BW-1:0]   r_p;

    assign a_pad = PADW'(i_a);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < NC; i++) begin
                r_pp[i] <= PPW'(a_pad[i*CHUNK_W +: CHUNK_W]) * PPW'(i_b);
            end
            r_p <= (AW+BW)'(n_acc);
        end
    end

    always_comb begin
        n_acc = '0;
        for (int i = 0; i < NC; i++) begin
            n_acc = n_acc + ((PADW+BW)'(r_pp[i]) << (i*CHUNK_W));
        end
    end

    assign o_p = r_p;

endmodule

`default_nettype wire

// ===== hw/rtl/ec2d_div.sv =====
// ec2d_div: pipelined restoring divider, one quotient bit per stage, rounding
// half away from zero and clamping to SHARE_CAP. Depends on ec2d_pkg.
`default_nettype none

module ec2d_div import ec2d_pkg::*; #(
    parameter int NW   = 92,
    parameter int DENW = 67
) (
    input  wire logic            i_clk,
    input  wire logic            i_en,
    input  wire logic [NW-1:0]   i_num,
    input  wire logic [DENW-1:0] i_den,
    output logic      [Q_W-1:0]  o_quot
);
    localparam int CMP_W = DENW + Q_W;

    // stage 0 checks for a quotient too large, stages 1..Q_W take one bit each
    logic [DENW-1:0] r_rem [Q_W+1];
    logic [Q_W-1:0]  r_qd  [Q_W+1];   // dividend bits shift out, quotient bits in
    logic [DENW-1:0] r_den [Q_W+1];
    logic            r_ovf [Q_W+1];
    logic [Q_W-1:0]  r_quot;

    logic [DENW:0]   n_sh  [Q_W];
    logic            n_ge  [Q_W];
    logic            n_rnd;
    logic [Q_W:0]    n_qr;

    always_comb begin
        for (int k = 0; k < Q_W; k++) begin
            n_sh[k] = {r_rem[k], r_qd[k][Q_W-1]};
            n_ge[k] = n_sh[k] >= {1'b0, r_den[k]};
        end
        n_rnd = {r_rem[Q_W], 1'b0} >= {1'b0, r_den[Q_W]};
        n_qr  = (Q_W+1)'(r_qd[Q_W]) + (Q_W+1)'(n_rnd);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ovf[0] <= CMP_W'(i_num) >= {i_den, {Q_W{1'b0}}};
            r_rem[0] <= DENW'(i_num >> Q_W);
            r_qd[0]  <= i_num[Q_W-1:0];
            r_den[0] <= i_den;
            for (int k = 0; k < Q_W; k++) begin
                r_rem[k+1] <= n_ge[k] ? DENW'(n_sh[k] - {1'b0, r_den[k]}) : DENW'(n_sh[k]);
                r_qd[k+1]  <= {r_qd[k][Q_W-2:0], n_ge[k]};
                r_den[k+1] <= r_den[k];
                r_ovf[k+1] <= r_ovf[k];
            end
            if (r_ovf[Q_W] || n_qr > (Q_W+1)'(SHARE_CAP)) begin
                r_quot <= SHARE_CAP;
            end else begin
                r_quot <= Q_W'(n_qr);
            end
        end
    end

    assign o_quot = r_quot;

endmodule

`default_nettype wire

// ===== hw/rtl/elastic_collision_2d.sv =====
// elastic_collision_2d: streaming 2D elastic collision of two disks.
// Depends on ec2d_pkg, ec2d_in_if, ec2d_out_if, ec2d_wmul and ec2d_div.
//
// Usage: a request on i_pair carries both positions, velocities and masses;
// the result on o_result carries both new velocities, the approaching flag and
// the degenerate flag (coincident positions or zero mass sum, velocities pass
// through). Both channels transfer when valid and ready are high together.
// Throughput: one request per cycle, back to back, while the skid entry is empty.
// Path from acceptance to the result showing valid on o_result:
// 7 stages of differences, products and wide multiplies, then a 43-stage
// divider (range check, 41 quotient bits, rounding), one output register.
// The whole pipe moves on one enable; a two-entry output buffer (register plus
// skid) means a stalled receiver holds the pipe only once the skid fills, so
// nothing is lost or repeated, and i_pair.ready depends on registers only.
// Reset clears all valid bits; no request is in flight afterwards.
`default_nettype none

module elastic_collision_2d import ec2d_pkg::*; #(
    parameter int COORD_WIDTH = 24
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    ec2d_in_if.sink    i_pair,
    ec2d_out_if.source o_result
);
    localparam int CW    = COORD_WIDTH;
    localparam int DW    = CW + 1;          // differences, magnitudes
    localparam int PW    = 2 * CW + 2;      // products, dot magnitude, |d|^2
    localparam int AW    = PW + MSUM_W;     // den, dot * 2m
    localparam int NW    = AW + DW;         // numerators
    localparam int S_DIV = 7;
    localparam int NS    = S_DIV + Q_W + 2; // pipeline stages before the output
    localparam int SW    = Q_W + 3;

    typedef struct packed {
        logic signed [CW-1:0] v1x;
        logic signed [CW-1:0] v1y;
        logic signed [CW-1:0] v2x;
        logic signed [CW-1:0] v2y;
        logic                 sx;
        logic                 sy;
        logic [DW-1:0]        adx;
        logic [DW-1:0]        ady;
        logic                 dot_neg;
        logic                 degen;
    } t_sb;

    typedef struct packed {
        logic signed [CW-1:0] n1x;
        logic signed [CW-1:0] n1y;
        logic signed [CW-1:0] n2x;
        logic signed [CW-1:0] n2y;
        logic                 appr;
        logic                 degen;
    } t_res;

    function automatic logic signed [CW-1:0] f_apply(
        input logic signed [CW-1:0] vel,
        input logic [Q_W-1:0]       q,
        input logic                 neg,
        input logic                 sub
    );
        logic signed [SW-1:0] s;
        logic signed [SW-1:0] r;
        logic signed [SW-1:0] hi;
        logic signed [SW-1:0] lo;
        s  = neg ? -$signed(SW'(q)) : $signed(SW'(q));
        r  = sub ? SW'(vel) - s : SW'(vel) + s;
        hi = $signed(SW'({1'b0, {(CW-1){1'b1}}}));
        lo = -hi - SW'(1);
        if (r > hi) begin
            return CW'(hi);
        end else if (r < lo) begin
            return CW'(lo);
        end
        return CW'(r);
    endfunction

    logic          en;
    logic [NS-1:0] r_v;
    t_sb           r_sb [NS];
    t_sb           n_sb0, n_sb1, n_sb2;

    // stage 0
    logic signed [DW-1:0] r_dx, r_dy, r_dvx, r_dvy;
    logic [MASS_W-1:0]    r_m1, r_m2;
    // stage 1
    logic signed [PW-1:0] r_px, r_py;
    logic [PW-1:0]        r_ddx, r_ddy;
    logic [MSUM_W-1:0]    r_msum1, r_tm1_1, r_tm2_1;
    logic [DW-1:0]        n_adx, n_ady;
    // stage 2
    logic signed [PW:0]   n_dot;
    logic [PW-1:0]        n_d2;
    logic [PW-1:0]        r_dmag, r_d2;
    logic [MSUM_W-1:0]    r_msum2, r_tm1_2, r_tm2_2;
    // stages 3..6, divider outputs
    logic [AW-1:0]        w_den, w_a1, w_a2, r_den5, r_den6;
    logic [NW-1:0]        w_n1x, w_n1y, w_n2x, w_n2y;
    logic [Q_W-1:0]       w_q1x, w_q1y, w_q2x, w_q2y;
    // output buffer
    t_res                 n_res, r_out, r_skid;
    logic                 r_out_v, r_skid_v, take;

    assign en           = !r_skid_v;
    assign i_pair.ready = en;
    assign take         = r_out_v && o_result.ready;

    always_comb begin
        n_sb0         = '0;
        n_sb0.v1x     = i_pair.first_vel_x;
        n_sb0.v1y     = i_pair.first_vel_y;
        n_sb0.v2x     = i_pair.second_vel_x;
        n_sb0.v2y     = i_pair.second_vel_y;

        n_adx = r_dx[DW-1] ? DW'(-r_dx) : DW'(r_dx);
        n_ady = r_dy[DW-1] ? DW'(-r_dy) : DW'(r_dy);

        n_dot = (PW+1)'(r_px) + (PW+1)'(r_py);
        n_d2  = r_ddx + r_ddy;

        n_sb1     = r_sb[0];
        n_sb1.adx = n_adx;
        n_sb1.ady = n_ady;
        n_sb1.sx  = r_dx[DW-1];
        n_sb1.sy  = r_dy[DW-1];

        n_sb2         = r_sb[1];
        n_sb2.dot_neg = n_dot[PW];
        n_sb2.degen   = (n_d2 == '0) || (r_msum1 == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (en) begin
            r_v <= {r_v[NS-2:0], i_pair.valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sb[0] <= n_sb0;
            r_sb[1] <= n_sb1;
            r_sb[2] <= n_sb2;
            for (int k = 3; k < NS; k++) begin
                r_sb[k] <= r_sb[k-1];
            end

            r_dx  <= DW'(i_pair.first_pos_x) - DW'(i_pair.second_pos_x);
            r_dy  <= DW'(i_pair.first_pos_y) - DW'(i_pair.second_pos_y);
            r_dvx <= DW'(i_pair.first_vel_x) - DW'(i_pair.second_vel_x);
            r_dvy <= DW'(i_pair.first_vel_y) - DW'(i_pair.second_vel_y);
            r_m1  <= i_pair.first_mass;
            r_m2  <= i_pair.second_mass;

            r_px    <= PW'(r_dvx) * PW'(r_dx);
            r_py    <= PW'(r_dvy) * PW'(r_dy);
            r_ddx   <= PW'(n_adx) * PW'(n_adx);
            r_ddy   <= PW'(n_ady) * PW'(n_ady);
            r_msum1 <= MSUM_W'(r_m1) + MSUM_W'(r_m2);
            r_tm1_1 <= {r_m1, 1'b0};
            r_tm2_1 <= {r_m2, 1'b0};

            r_dmag  <= n_dot[PW] ? PW'(-n_dot) : PW'(n_dot);
            r_d2    <= n_d2;
            r_msum2 <= r_msum1;
            r_tm1_2 <= r_tm1_1;
            r_tm2_2 <= r_tm2_1;

            r_den5 <= w_den;
            r_den6 <= r_den5;
        end
    end

    ec2d_wmul #(.AW(PW), .BW(MSUM_W)) u_mul_den (
        .i_clk(i_clk), .i_en(en), .i_a(r_d2),   .i_b(r_msum2), .o_p(w_den));
    ec2d_wmul #(.AW(PW), .BW(MSUM_W)) u_mul_a1 (
        .i_clk(i_clk), .i_en(en), .i_a(r_dmag), .i_b(r_tm2_2), .o_p(w_a1));
    ec2d_wmul #(.AW(PW), .BW(MSUM_W)) u_mul_a2 (
        .i_clk(i_clk), .i_en(en), .i_a(r_dmag), .i_b(r_tm1_2), .o_p(w_a2));

    ec2d_wmul #(.AW(AW), .BW(DW)) u_mul_n1x (
        .i_clk(i_clk), .i_en(en), .i_a(w_a1), .i_b(r_sb[4].adx), .o_p(w_n1x));
    ec2d_wmul #(.AW(AW), .BW(DW)) u_mul_n1y (
        .i_clk(i_clk), .i_en(en), .i_a(w_a1), .i_b(r_sb[4].ady), .o_p(w_n1y));
    ec2d_wmul #(.AW(AW), .BW(DW)) u_mul_n2x (
        .i_clk(i_clk), .i_en(en), .i_a(w_a2), .i_b(r_sb[4].adx), .o_p(w_n2x));
    ec2d_wmul #(.AW(AW), .BW(DW)) u_mul_n2y (
        .i_clk(i_clk), .i_en(en), .i_a(w_a2), .i_b(r_sb[4].ady), .o_p(w_n2y));

    ec2d_div #(.NW(NW), .DENW(AW)) u_div_1x (
        .i_clk(i_clk), .i_en(en), .i_num(w_n1x), .i_den(r_den6), .o_quot(w_q1x));
    ec2d_div #(.NW(NW), .DENW(AW)) u_div_1y (
        .i_clk(i_clk), .i_en(en), .i_num(w_n1y), .i_den(r_den6), .o_quot(w_q1y));
    ec2d_div #(.NW(NW), .DENW(AW)) u_div_2x (
        .i_clk(i_clk), .i_en(en), .i_num(w_n2x), .i_den(r_den6), .o_quot(w_q2x));
    ec2d_div #(.NW(NW), .DENW(AW)) u_div_2y (
        .i_clk(i_clk), .i_en(en), .i_num(w_n2y), .i_den(r_den6), .o_quot(w_q2y));

    // share sign is sign(dot) xor sign(d); first body subtracts, second adds
    always_comb begin
        n_res.appr  = r_sb[NS-1].dot_neg;
        n_res.degen = r_sb[NS-1].degen;
        if (r_sb[NS-1].degen) begin
            n_res.n1x = r_sb[NS-1].v1x;
            n_res.n1y = r_sb[NS-1].v1y;
            n_res.n2x = r_sb[NS-1].v2x;
            n_res.n2y = r_sb[NS-1].v2y;
        end else begin
            n_res.n1x = f_apply(r_sb[NS-1].v1x, w_q1x,
                                r_sb[NS-1].dot_neg ^ r_sb[NS-1].sx, 1'b1);
            n_res.n1y = f_apply(r_sb[NS-1].v1y, w_q1y,
                                r_sb[NS-1].dot_neg ^ r_sb[NS-1].sy, 1'b1);
            n_res.n2x = f_apply(r_sb[NS-1].v2x, w_q2x,
                                r_sb[NS-1].dot_neg ^ r_sb[NS-1].sx, 1'b0);
            n_res.n2y = f_apply(r_sb[NS-1].v2y, w_q2y,
                                r_sb[NS-1].dot_neg ^ r_sb[NS-1].sy, 1'b0);
        end
    end

    // en implies an empty skid, so a new result and a skid refill never coincide
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (en && r_v[NS-1]) begin
            if (!r_out_v || take) begin
                r_out_v <= 1'b1;
            end else begin
                r_skid_v <= 1'b1;
            end
        end else if (take) begin
            r_out_v  <= r_skid_v;
            r_skid_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en && r_v[NS-1]) begin
            if (!r_out_v || take) begin
                r_out <= n_res;
            end else begin
                r_skid <= n_res;
            end
        end else if (take && r_skid_v) begin
            r_out <= r_skid;
        end
    end

    assign o_result.valid            = r_out_v;
    assign o_result.first_new_vel_x  = r_out.n1x;
    assign o_result.first_new_vel_y  = r_out.n1y;
    assign o_result.second_new_vel_x = r_out.n2x;
    assign o_result.second_new_vel_y = r_out.n2y;
    assign o_result.approaching      = r_out.appr;
    assign o_result.degenerate       = r_out.degen;

endmodule

`default_nettype wire
